@@ rtl/core/mfte_pkg.sv @@
// Shared constants, command codes and types for the monochrome frame buffer text engine.
package mfte_pkg;

	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 64;
	localparam int GLYPH_WIDTH_DEF   = 7;
	localparam int GLYPH_HEIGHT_DEF  = 10;
	localparam int GLYPH_COUNT_DEF   = 95;

	localparam int HEAD_LEN     = 4;
	localparam int PAGE_W       = 3;
	localparam int CODE_FIRST   = 32;
	localparam int CODE_LAST    = 126;
	localparam int FONT_MSB     = 15;

	localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
	localparam logic [7:0] COL_LOW_CMD   = 8'h00;
	localparam logic [7:0] COL_HIGH_CMD  = 8'h10;

	typedef enum logic [2:0] {
		CMD_FILL       = 3'd0,
		CMD_PIXEL      = 3'd1,
		CMD_CHAR       = 3'd2,
		CMD_CURSOR_PIX = 3'd3,
		CMD_CURSOR_CEL = 3'd4,
		CMD_FONT_ROW   = 3'd5,
		CMD_REFRESH    = 3'd6
	} cmd_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_FILL  = 7'b0000010,
		ST_WB    = 7'b0000100,
		ST_GFONT = 7'b0001000,
		ST_GPIX  = 7'b0010000,
		ST_RDATA = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	// Write request into the frame store: either a pixel merge or a whole-byte fill.
	typedef struct packed {
		logic       en;
		logic       merge;
		logic       bit_val;
		logic [2:0] bit_sel;
		logic [7:0] fill_byte;
	} fm_wr_t;

	function automatic logic [7:0] head_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h20;
			2'd1: b = 8'h10;
			2'd2: b = 8'hD3;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/core/mfte_frame_mem.sv @@
// Frame store memory with a registered read port and a read-modify-write pixel merge.
module mfte_frame_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic              clk,
	input  logic [AW-1:0]     rd_addr,
	output logic [7:0]        rd_data,
	input  logic [AW-1:0]     wr_addr,
	input  mfte_pkg::fm_wr_t  wr
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;
	logic [7:0] mask;
	logic [7:0] wdata;

	// The merge uses the byte read in the previous cycle from the same address.
	assign mask    = 8'(1) << wr.bit_sel;
	assign wdata   = wr.merge ? (wr.bit_val ? (rd_data_q | mask) : (rd_data_q & ~mask))
	                          : wr.fill_byte;
	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

endmodule

@@ rtl/core/mono_framebuffer_text_engine.sv @@
// From the accepting edge an item passes through these states before ST_DONE loads its
// result: pixel ST_WB; glyph ST_GFONT then ST_GPIX for each row, then ST_WB; fill ST_FILL
// over every frame byte; refresh data bytes ST_RDATA; cursor, font row, rejected items and
// other refresh bytes none. One item is in work at a time, and a result waits in an output
// register. After reset a clearing pass writes zero to every frame byte with the input
// stalled; the font store is undefined until written.
module mono_framebuffer_text_engine #(
	parameter int SCREEN_WIDTH  = mfte_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = mfte_pkg::SCREEN_HEIGHT_DEF,
	parameter int GLYPH_WIDTH   = mfte_pkg::GLYPH_WIDTH_DEF,
	parameter int GLYPH_HEIGHT  = mfte_pkg::GLYPH_HEIGHT_DEF,
	parameter int GLYPH_COUNT   = mfte_pkg::GLYPH_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [6:0]  pos_x,
	input  logic [5:0]  pos_y,
	input  logic        color,
	input  logic [6:0]  char_code,
	input  logic [9:0]  font_index,
	input  logic [15:0] font_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [7:0]  out_byte,
	output logic        is_data,
	output logic        frame_last
);

	localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
	localparam int FRAME_BYTES = SCREEN_WIDTH * PAGE_COUNT;
	localparam int FA          = $clog2(FRAME_BYTES);
	localparam int FD          = GLYPH_COUNT * GLYPH_HEIGHT;
	localparam int FWA         = (FD > 1) ? $clog2(FD) : 1;
	localparam int PAGE_LEN    = 3 + SCREEN_WIDTH;
	localparam int SEQ_LEN     = mfte_pkg::HEAD_LEN + PAGE_COUNT * PAGE_LEN;
	localparam int RPW         = $clog2(SEQ_LEN);
	localparam int CW          = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
	localparam int RW          = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
	localparam int CELL_COLS   = SCREEN_WIDTH / GLYPH_WIDTH;
	localparam int CELL_ROWS   = SCREEN_HEIGHT / GLYPH_HEIGHT;
	localparam int PW          = mfte_pkg::PAGE_W;

	mfte_pkg::state_t st_q;
	logic             fill_rst_q;
	logic [7:0]       fill_byte_q;
	logic [FA-1:0]    fcnt_q;

	logic [6:0]       cursor_x_q;
	logic [5:0]       cursor_y_q;
	logic [RPW-1:0]   rpos_q;
	logic [7:0]       rr_q;
	logic [PW-1:0]    rpage_q;

	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [FWA-1:0]   font_addr_q;
	logic [15:0]      font_q;
	logic [15:0]      font_mem [FD];

	logic             v_s1;
	logic [FA-1:0]    addr_s1;
	logic             bit_s1;
	logic [2:0]       sel_s1;

	logic             res_status_q;
	logic [7:0]       res_byte_q;
	logic             res_data_q;
	logic             res_last_q;

	logic             out_valid_q;
	logic             status_q;
	logic [7:0]       out_byte_q;
	logic             is_data_q;
	logic             frame_last_q;

	logic             accept;
	logic [6:0]       gx;
	logic [5:0]       gy;
	logic [FA-1:0]    gaddr;
	logic [FA-1:0]    paddr;
	logic [FA-1:0]    raddr;
	logic [FA-1:0]    rd_addr;
	logic [7:0]       rd_data;
	logic [FA-1:0]    wr_addr;
	mfte_pkg::fm_wr_t wr;
	logic             pix_bad;
	logic             char_bad;
	logic             cell_bad;
	logic             glyph_last_col;
	logic             glyph_last_row;
	logic             fill_last;
	logic             seq_last;
	logic [3:0]       font_bit_idx;

	assign accept   = in_valid && (st_q == mfte_pkg::ST_IDLE);
	assign in_stall = (st_q != mfte_pkg::ST_IDLE);

	assign gx    = cursor_x_q + 7'(col_q);
	assign gy    = cursor_y_q + 6'(row_q);
	assign gaddr = FA'(gx) + FA'(gy[5:3]) * FA'(SCREEN_WIDTH);
	assign paddr = FA'(pos_x) + FA'(pos_y[5:3]) * FA'(SCREEN_WIDTH);
	assign raddr = FA'(rr_q - 8'd3) + FA'(rpage_q) * FA'(SCREEN_WIDTH);

	assign pix_bad  = (32'(pos_x) >= SCREEN_WIDTH) || (32'(pos_y) >= SCREEN_HEIGHT);
	assign cell_bad = (32'(pos_x) >= CELL_COLS) || (32'(pos_y) >= CELL_ROWS);
	assign char_bad = (32'(char_code) < mfte_pkg::CODE_FIRST)
	               || (32'(char_code) > mfte_pkg::CODE_LAST)
	               || (32'(char_code) - mfte_pkg::CODE_FIRST >= GLYPH_COUNT)
	               || (32'(cursor_x_q) + GLYPH_WIDTH >= SCREEN_WIDTH)
	               || (32'(cursor_y_q) + GLYPH_HEIGHT >= SCREEN_HEIGHT);

	assign glyph_last_col = (col_q == CW'(GLYPH_WIDTH - 1));
	assign glyph_last_row = (row_q == RW'(GLYPH_HEIGHT - 1));
	assign fill_last      = (fcnt_q == FA'(FRAME_BYTES - 1));
	assign seq_last       = (rpos_q == RPW'(SEQ_LEN - 1));
	assign font_bit_idx   = 4'(mfte_pkg::FONT_MSB) - 4'(col_q);

	always_comb begin
		rd_addr = '0;
		if (st_q == mfte_pkg::ST_GPIX) begin
			rd_addr = gaddr;
		end else if (cmd == mfte_pkg::CMD_PIXEL) begin
			rd_addr = paddr;
		end else begin
			rd_addr = raddr;
		end
	end

	always_comb begin
		wr.en        = v_s1 || (st_q == mfte_pkg::ST_FILL);
		wr.merge     = v_s1;
		wr.bit_val   = bit_s1;
		wr.bit_sel   = sel_s1;
		wr.fill_byte = fill_byte_q;
		wr_addr      = v_s1 ? addr_s1 : fcnt_q;
	end

	mfte_frame_mem #(
		.DEPTH(FRAME_BYTES),
		.AW   (FA)
	) u_frame (
		.clk    (clk),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_addr(wr_addr),
		.wr     (wr)
	);

	// The glyph row is fetched once per row and held while its pixels are drawn.
	always_ff @(posedge clk) begin
		if (accept && (cmd == mfte_pkg::CMD_FONT_ROW) && (32'(font_index) < FD)) begin
			font_mem[FWA'(font_index)] <= font_bits;
		end
		if (st_q == mfte_pkg::ST_GFONT) begin
			font_q <= font_mem[font_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= mfte_pkg::ST_FILL;
			fill_rst_q   <= 1'b1;
			fill_byte_q  <= 8'h00;
			fcnt_q       <= '0;
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			rpos_q       <= '0;
			rr_q         <= '0;
			rpage_q      <= '0;
			col_q        <= '0;
			row_q        <= '0;
			font_addr_q  <= '0;
			v_s1         <= 1'b0;
			addr_s1      <= '0;
			bit_s1       <= 1'b0;
			sel_s1       <= '0;
			res_status_q <= 1'b0;
			res_byte_q   <= '0;
			res_data_q   <= 1'b0;
			res_last_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			status_q     <= 1'b0;
			out_byte_q   <= '0;
			is_data_q    <= 1'b0;
			frame_last_q <= 1'b0;
		end else begin
			v_s1 <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				mfte_pkg::ST_IDLE: begin
					if (accept) begin
						res_status_q <= 1'b0;
						res_byte_q   <= '0;
						res_data_q   <= 1'b0;
						res_last_q   <= 1'b0;
						st_q         <= mfte_pkg::ST_DONE;
						case (cmd)
							mfte_pkg::CMD_FILL: begin
								fill_byte_q <= color ? 8'hFF : 8'h00;
								fcnt_q      <= '0;
								fill_rst_q  <= 1'b0;
								st_q        <= mfte_pkg::ST_FILL;
							end
							mfte_pkg::CMD_PIXEL: begin
								if (pix_bad) begin
									res_status_q <= 1'b1;
								end else begin
									v_s1    <= 1'b1;
									addr_s1 <= paddr;
									bit_s1  <= color;
									sel_s1  <= pos_y[2:0];
									st_q    <= mfte_pkg::ST_WB;
								end
							end
							mfte_pkg::CMD_CHAR: begin
								if (char_bad) begin
									res_status_q <= 1'b1;
								end else begin
									font_addr_q <= FWA'((32'(char_code) - mfte_pkg::CODE_FIRST)
									               * GLYPH_HEIGHT);
									row_q       <= '0;
									col_q       <= '0;
									st_q        <= mfte_pkg::ST_GFONT;
								end
							end
							mfte_pkg::CMD_CURSOR_PIX: begin
								if (pix_bad) begin
									res_status_q <= 1'b1;
								end else begin
									cursor_x_q <= pos_x;
									cursor_y_q <= pos_y;
								end
							end
							mfte_pkg::CMD_CURSOR_CEL: begin
								if (cell_bad) begin
									res_status_q <= 1'b1;
								end else begin
									cursor_x_q <= 7'(32'(pos_x) * GLYPH_WIDTH);
									cursor_y_q <= 6'(32'(pos_y) * GLYPH_HEIGHT);
								end
							end
							mfte_pkg::CMD_FONT_ROW: begin
								res_status_q <= (32'(font_index) >= FD);
							end
							mfte_pkg::CMD_REFRESH: begin
								res_last_q <= seq_last;
								if (32'(rpos_q) < mfte_pkg::HEAD_LEN) begin
									res_byte_q <= mfte_pkg::head_byte(rpos_q[1:0]);
								end else if (rr_q == 8'd0) begin
									res_byte_q <= mfte_pkg::PAGE_CMD_BASE + 8'(rpage_q);
								end else if (rr_q == 8'd1) begin
									res_byte_q <= mfte_pkg::COL_LOW_CMD;
								end else if (rr_q == 8'd2) begin
									res_byte_q <= mfte_pkg::COL_HIGH_CMD;
								end else begin
									res_data_q <= 1'b1;
									st_q       <= mfte_pkg::ST_RDATA;
								end
								// Step the sequence position; page and offset follow the head.
								if (seq_last) begin
									rpos_q  <= '0;
									rr_q    <= '0;
									rpage_q <= '0;
								end else begin
									rpos_q <= rpos_q + RPW'(1);
									if (32'(rpos_q) >= mfte_pkg::HEAD_LEN) begin
										if (rr_q == 8'(PAGE_LEN - 1)) begin
											rr_q    <= '0;
											rpage_q <= rpage_q + PW'(1);
										end else begin
											rr_q <= rr_q + 8'd1;
										end
									end
								end
							end
							default: begin
								res_status_q <= 1'b1;
							end
						endcase
					end
				end
				mfte_pkg::ST_FILL: begin
					fcnt_q <= fcnt_q + FA'(1);
					if (fill_last) begin
						st_q       <= fill_rst_q ? mfte_pkg::ST_IDLE : mfte_pkg::ST_DONE;
						fill_rst_q <= 1'b0;
					end
				end
				mfte_pkg::ST_WB: begin
					st_q <= mfte_pkg::ST_DONE;
				end
				mfte_pkg::ST_GFONT: begin
					font_addr_q <= font_addr_q + FWA'(1);
					col_q       <= '0;
					st_q        <= mfte_pkg::ST_GPIX;
				end
				mfte_pkg::ST_GPIX: begin
					v_s1    <= 1'b1;
					addr_s1 <= gaddr;
					bit_s1  <= font_q[font_bit_idx];
					sel_s1  <= gy[2:0];
					col_q   <= col_q + CW'(1);
					if (glyph_last_col) begin
						if (glyph_last_row) begin
							cursor_x_q <= cursor_x_q + 7'(GLYPH_WIDTH);
							st_q       <= mfte_pkg::ST_WB;
						end else begin
							row_q <= row_q + RW'(1);
							st_q  <= mfte_pkg::ST_GFONT;
						end
					end
				end
				mfte_pkg::ST_RDATA: begin
					res_byte_q <= rd_data;
					st_q       <= mfte_pkg::ST_DONE;
				end
				mfte_pkg::ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						status_q     <= res_status_q;
						out_byte_q   <= res_byte_q;
						is_data_q    <= res_data_q;
						frame_last_q <= res_last_q;
						st_q         <= mfte_pkg::ST_IDLE;
					end
				end
				default: begin
					st_q <= mfte_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_byte   = out_byte_q;
	assign is_data    = is_data_q;
	assign frame_last = frame_last_q;

`ifndef NO_ASSERTIONS
	a_merge_in_draw: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (st_q == mfte_pkg::ST_WB || st_q == mfte_pkg::ST_GFONT
		          || st_q == mfte_pkg::ST_GPIX))
		else $error("pixel write-back outside a draw");
	a_no_fill_merge: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 && st_q == mfte_pkg::ST_FILL))
		else $error("fill and pixel merge collide");
	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_last_q) |-> is_data_q)
		else $error("last refresh byte is not a data byte");
	a_head_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(rr_q != 8'd0) |-> (32'(rpos_q) >= mfte_pkg::HEAD_LEN))
		else $error("page offset moved during head");
`endif

endmodule
